// ===== rtl/core/rpa_pkg.sv =====
// Shared constants and types for the ring pixel to angle converter.
// Used by rpa_tail and ring_pixel_to_angle; depends on nothing.
package rpa_pkg;

    localparam int RES_W      = 14;
    localparam int PIX_W      = 30;
    localparam logic [RES_W-1:0] MAX_RES = 14'd8192;
    localparam int FRAC_BITS  = 30;
    localparam int FRAC_STEPS = FRAC_BITS + 1;
    localparam int PHI_STEPS  = 33;
    localparam int TAIL_DEPTH = PHI_STEPS + 2;
    // pi truncated to 61 fraction bits
    localparam logic [62:0] PI_Q61 = 63'h6487ED5110B4611A;

    typedef enum logic [1:0] {
        REGION_NORTH = 2'd0,
        REGION_BELT  = 2'd1,
        REGION_SOUTH = 2'd2
    } region_t;

    // one item handed from the ring finder to the fraction and azimuth unit
    typedef struct packed {
        logic        invalid;
        region_t     region;
        logic [14:0] ring;
        logic [15:0] iphi;
        logic        z_neg;
        logic [27:0] z_num;
        logic [27:0] z_den;
        logic [15:0] k;
        logic [13:0] m;
    } rpa_item_t;

endpackage

// ===== rtl/core/rpa_tail.sv =====
// Fraction divider for z and constant multiply plus divider for phi, with
// the output register. Depends on rpa_pkg.
module rpa_tail (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  rpa_pkg::rpa_item_t  in_item,
    output logic                out_valid,
    output logic [31:0]         z_value,
    output logic [31:0]         phi_value,
    output logic [1:0]          region,
    output logic [14:0]         ring_number,
    output logic [15:0]         index_in_ring,
    output logic                pixel_invalid
);
    import rpa_pkg::*;

    localparam logic [31:0] PI_LO = PI_Q61[31:0];
    localparam logic [30:0] PI_HI = PI_Q61[62:32];
    localparam logic [31:0] Z_ONE = 32'd1 << FRAC_BITS;

    typedef struct packed {
        rpa_item_t   item;
        logic [27:0] f_rem;
        logic [30:0] f_q;
        logic [47:0] pa;
        logic [46:0] pb;
        logic [15:0] p_rem;
        logic [32:0] p_bits;
        logic [32:0] p_q;
    } tl_t;

    tl_t                   st_reg  [0:TAIL_DEPTH-1];
    tl_t                   st_next [0:TAIL_DEPTH-1];
    logic [TAIL_DEPTH-1:0] st_valid_reg;

    for (genvar j = 0; j < TAIL_DEPTH; j++) begin : g_st
        tl_t p;

        if (j == 0) begin : g_src
            always_comb
            begin
                p        = '0;
                p.item   = in_item;
                p.f_rem  = in_item.z_num;
            end
        end else begin : g_src
            assign p = st_reg[j-1];
        end

        always_comb
        begin
            logic [28:0] f_cur;
            logic [16:0] p_cur;
            logic [15:0] p_den;
            logic [47:0] x;
            f_cur = {p.f_rem, 1'b0};
            p_den = {p.item.m, 2'b00};
            p_cur = {p.p_rem, p.p_bits[32]};
            x     = {p.pb, 1'b0} + {31'd0, p.pa[47:31]};
            st_next[j] = p;
            // one quotient bit of the z fraction per stage
            if (j < FRAC_STEPS)
            begin
                if (f_cur >= {1'b0, p.item.z_den})
                begin
                    st_next[j].f_rem = 28'(f_cur - {1'b0, p.item.z_den});
                    st_next[j].f_q   = {p.f_q[29:0], 1'b1};
                end else begin
                    st_next[j].f_rem = f_cur[27:0];
                    st_next[j].f_q   = {p.f_q[29:0], 1'b0};
                end
            end
            if (j == 0)
            begin
                st_next[j].pa = {32'd0, p.item.k} * {16'd0, PI_LO};
                st_next[j].pb = {31'd0, p.item.k} * {16'd0, PI_HI};
            end else if (j == 1)
            begin
                // x = floor(k * pi_q61 / 2^31); top bits are already below 4m
                st_next[j].p_rem  = {1'b0, x[47:33]};
                st_next[j].p_bits = x[32:0];
                st_next[j].p_q    = '0;
            end else begin
                st_next[j].p_bits = {p.p_bits[31:0], 1'b0};
                if (p_cur >= {1'b0, p_den})
                begin
                    st_next[j].p_rem = 16'(p_cur - {1'b0, p_den});
                    st_next[j].p_q   = {p.p_q[31:0], 1'b1};
                end else begin
                    st_next[j].p_rem = p_cur[15:0];
                    st_next[j].p_q   = {p.p_q[31:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= '0;
        end else if (adv)
        begin
            st_valid_reg <= {st_valid_reg[TAIL_DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < TAIL_DEPTH; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    // output formatting
    tl_t         last;
    logic [31:0] z_sum;
    logic [31:0] z_mag;
    logic [31:0] z_abs;
    logic [33:0] p_sum;
    logic        out_valid_reg;
    logic [31:0] z_value_reg;
    logic [31:0] phi_value_reg;
    logic [1:0]  region_reg;
    logic [14:0] ring_reg;
    logic [15:0] iphi_reg;
    logic        invalid_reg;

    assign last  = st_reg[TAIL_DEPTH-1];
    assign z_sum = {1'b0, last.f_q} + 32'd1;
    assign z_mag = {1'b0, z_sum[31:1]};
    assign z_abs = (last.item.region != REGION_BELT) ? (Z_ONE - z_mag) : z_mag;
    assign p_sum = {1'b0, last.p_q} + 34'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end else if (adv)
        begin
            out_valid_reg <= st_valid_reg[TAIL_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (last.item.invalid)
            begin
                z_value_reg   <= '0;
                phi_value_reg <= '0;
                region_reg    <= '0;
                ring_reg      <= '0;
                iphi_reg      <= '0;
                invalid_reg   <= 1'b1;
            end else begin
                z_value_reg   <= last.item.z_neg ? (32'd0 - z_abs) : z_abs;
                phi_value_reg <= p_sum[32:1];
                region_reg    <= last.item.region;
                ring_reg      <= last.item.ring;
                iphi_reg      <= last.item.iphi;
                invalid_reg   <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign z_value       = z_value_reg;
    assign phi_value     = phi_value_reg;
    assign region        = region_reg;
    assign ring_number   = ring_reg;
    assign index_in_ring = iphi_reg;
    assign pixel_invalid = invalid_reg;

endmodule

// ===== rtl/core/ring_pixel_to_angle.sv =====
// Ring-ordered sphere grid: pixel index to z = cos(theta) and phi.
// One item per cycle while the output item is taken or no output item is pending.
// Depth is set by the 15-step root/divide section and the 33-step phi divider.
// The whole pipeline holds while the output item is not taken.
// Reset (rst_n low, asynchronous) clears all valid bits and sets resolution to 1.
// Depends on rpa_pkg and rpa_tail.
module ring_pixel_to_angle (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      resolution_we,
    input  logic [rpa_pkg::RES_W-1:0] resolution_wdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [31:0]               s_axis_tdata,  // pixel_index[29:0]
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [95:0]               m_axis_tdata,  // z_value, phi_value, ring_number,
                                                     // index_in_ring
    output logic [2:0]                m_axis_tuser   // region[1:0], pixel_invalid
);
    import rpa_pkg::*;

    localparam int ROOT_STEPS = 15;

    logic adv;

    // configuration and derived grid sizes
    logic [RES_W-1:0] resolution_reg;
    logic [13:0]      n_c;
    logic [31:0]      n32;
    logic [31:0]      nn32;
    logic [13:0]      n_reg;
    logic [14:0]      two_n_reg;
    logic [15:0]      four_n_reg;
    logic [14:0]      three_n_reg;
    logic [27:0]      three_nn_reg;
    logic [26:0]      ncap_reg;
    logic [29:0]      npix_reg;
    logic [29:0]      belt_end_reg;
    logic [29:0]      npix_c;
    logic [26:0]      ncap_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg <= 14'd1;
        end else if (resolution_we)
        begin
            resolution_reg <= resolution_wdata;
        end
    end

    always_comb
    begin
        if (resolution_reg == '0)
        begin
            n_c = 14'd1;
        end else if (resolution_reg > MAX_RES)
        begin
            n_c = MAX_RES;
        end else begin
            n_c = resolution_reg;
        end
        n32    = {18'd0, n_c};
        nn32   = n32 * n32;
        npix_c = 30'((nn32 << 3) + (nn32 << 2));
        ncap_c = 27'((nn32 - n32) << 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg        <= 14'd1;
            two_n_reg    <= 15'd2;
            four_n_reg   <= 16'd4;
            three_n_reg  <= 15'd3;
            three_nn_reg <= 28'd3;
            ncap_reg     <= 27'd0;
            npix_reg     <= 30'd12;
            belt_end_reg <= 30'd12;
        end else begin
            n_reg        <= n_c;
            two_n_reg    <= {n_c, 1'b0};
            four_n_reg   <= {n_c, 2'b00};
            three_n_reg  <= {n_c, 1'b0} + {1'b0, n_c};
            three_nn_reg <= 28'((nn32 << 1) + nn32);
            ncap_reg     <= ncap_c;
            npix_reg     <= npix_c;
            belt_end_reg <= npix_c - {3'd0, ncap_c};
        end
    end

    // input register
    logic        in_valid_reg;
    logic [29:0] pix_reg;

    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end else if (adv)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pix_reg <= s_axis_tdata[PIX_W-1:0];
        end
    end

    // region decode, then integer root (caps) and divide by 4n (belt) side by side
    typedef struct packed {
        logic        invalid;
        region_t     region;
        logic [26:0] a;
        logic [29:0] sq_v;
        logic [16:0] sq_rem;
        logic [14:0] sq_root;
        logic [14:0] d_bits;
        logic [15:0] d_rem;
        logic [14:0] d_q;
    } rs_t;

    function automatic rs_t root_step(input rs_t p, input logic [15:0] den);
        rs_t         nx;
        logic [18:0] sq_cur;
        logic [18:0] sq_try;
        logic [16:0] d_cur;
        nx     = p;
        sq_cur = {p.sq_rem, p.sq_v[29:28]};
        sq_try = {2'b00, p.sq_root, 2'b01};
        d_cur  = {p.d_rem, p.d_bits[14]};
        nx.sq_v   = {p.sq_v[27:0], 2'b00};
        nx.d_bits = {p.d_bits[13:0], 1'b0};
        if (sq_cur >= sq_try)
        begin
            nx.sq_rem  = 17'(sq_cur - sq_try);
            nx.sq_root = {p.sq_root[13:0], 1'b1};
        end else begin
            nx.sq_rem  = sq_cur[16:0];
            nx.sq_root = {p.sq_root[13:0], 1'b0};
        end
        if (d_cur >= {1'b0, den})
        begin
            nx.d_rem = 16'(d_cur - {1'b0, den});
            nx.d_q   = {p.d_q[13:0], 1'b1};
        end else begin
            nx.d_rem = d_cur[15:0];
            nx.d_q   = {p.d_q[13:0], 1'b0};
        end
        return nx;
    endfunction

    rs_t                 rs_reg  [0:ROOT_STEPS];
    rs_t                 rs_next [0:ROOT_STEPS];
    logic [ROOT_STEPS:0] rs_valid_reg;
    logic [29:0]         ips;
    logic [29:0]         ip_belt;

    always_comb
    begin
        ips     = npix_reg - pix_reg;
        ip_belt = pix_reg - {3'd0, ncap_reg};
        rs_next[0]         = '0;
        rs_next[0].invalid = (pix_reg >= npix_reg);
        rs_next[0].d_rem   = {1'b0, ip_belt[29:15]};
        rs_next[0].d_bits  = ip_belt[14:0];
        if (pix_reg < {3'd0, ncap_reg})
        begin
            rs_next[0].region = REGION_NORTH;
            rs_next[0].sq_v   = {pix_reg[28:0], 1'b1};
            rs_next[0].a      = pix_reg[26:0];
        end else if (pix_reg < belt_end_reg)
        begin
            rs_next[0].region = REGION_BELT;
        end else begin
            rs_next[0].region = REGION_SOUTH;
            rs_next[0].sq_v   = {ips[28:0], 1'b0} - 30'd1;
            rs_next[0].a      = ips[26:0];
        end
    end

    for (genvar j = 1; j <= ROOT_STEPS; j++) begin : g_root
        assign rs_next[j] = root_step(rs_reg[j-1], four_n_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_valid_reg <= '0;
        end else if (adv)
        begin
            rs_valid_reg <= {rs_valid_reg[ROOT_STEPS-1:0], in_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= ROOT_STEPS; i++)
            begin
                rs_reg[i] <= rs_next[i];
            end
        end
    end

    // ring and in-ring index
    typedef struct packed {
        logic        invalid;
        region_t     region;
        logic [26:0] a;
        logic [14:0] ring;
        logic [15:0] iphi_b;
    } r1_t;

    typedef struct packed {
        logic        invalid;
        region_t     region;
        logic [26:0] a;
        logic [14:0] ring;
        logic [15:0] iphi_b;
        logic [29:0] rsq;
        logic [13:0] dz;
        logic        belt_neg;
        logic        c_two;
    } r2_t;

    r1_t       r1_reg;
    r1_t       r1_next;
    r2_t       r2_reg;
    r2_t       r2_next;
    rpa_item_t r3_reg;
    rpa_item_t r3_next;
    logic      r3_c_two_reg;
    rpa_item_t r4_reg;
    rpa_item_t r4_next;
    logic [3:0] r_valid_reg;
    rs_t         rl;
    logic [15:0] root_inc;
    logic [29:0] t_c;
    logic [29:0] two_t;
    logic [16:0] k_wide;

    assign rl       = rs_reg[ROOT_STEPS];
    assign root_inc = {1'b0, rl.sq_root} + 16'd1;

    always_comb
    begin
        r1_next.invalid = rl.invalid;
        r1_next.region  = rl.region;
        r1_next.a       = rl.a;
        r1_next.iphi_b  = rl.d_rem + 16'd1;
        if (rl.region == REGION_BELT)
        begin
            r1_next.ring = rl.d_q + {1'b0, n_reg};
        end else begin
            r1_next.ring = root_inc[15:1];
        end
    end

    always_comb
    begin
        r2_next.invalid  = r1_reg.invalid;
        r2_next.region   = r1_reg.region;
        r2_next.a        = r1_reg.a;
        r2_next.ring     = r1_reg.ring;
        r2_next.iphi_b   = r1_reg.iphi_b;
        r2_next.rsq      = r1_reg.ring * r1_reg.ring;
        r2_next.belt_neg = (r1_reg.ring > two_n_reg);
        r2_next.c_two    = r1_reg.ring[0] ^ n_reg[0];
        if (r1_reg.ring > two_n_reg)
        begin
            r2_next.dz = 14'(r1_reg.ring - two_n_reg);
        end else begin
            r2_next.dz = 14'(two_n_reg - r1_reg.ring);
        end
    end

    always_comb
    begin
        t_c   = r2_reg.rsq - {15'd0, r2_reg.ring};
        two_t = {t_c[28:0], 1'b0};
        r3_next         = '0;
        r3_next.invalid = r2_reg.invalid;
        r3_next.region  = r2_reg.region;
        r3_next.ring    = r2_reg.ring;
        unique case (r2_reg.region)
            REGION_NORTH:
            begin
                r3_next.iphi  = 16'({3'd0, r2_reg.a} + 30'd1 - two_t);
                r3_next.z_neg = 1'b0;
            end
            REGION_SOUTH:
            begin
                r3_next.iphi  = 16'({13'd0, r2_reg.ring, 2'b00} + 30'd1
                                    - {3'd0, r2_reg.a} + two_t);
                r3_next.z_neg = 1'b1;
            end
            default:
            begin
                r3_next.iphi  = r2_reg.iphi_b;
                r3_next.z_neg = r2_reg.belt_neg;
            end
        endcase
        if (r2_reg.region == REGION_BELT)
        begin
            r3_next.z_num = {13'd0, r2_reg.dz, 1'b0};
            r3_next.z_den = {13'd0, three_n_reg};
            r3_next.m     = n_reg;
        end else begin
            r3_next.z_num = r2_reg.rsq[27:0];
            r3_next.z_den = three_nn_reg;
            r3_next.m     = r2_reg.ring[13:0];
        end
    end

    always_comb
    begin
        k_wide    = {r3_reg.iphi, 1'b0} - ((r3_reg.region == REGION_BELT && r3_c_two_reg)
                                           ? 17'd2 : 17'd1);
        r4_next   = r3_reg;
        r4_next.k = k_wide[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= '0;
        end else if (adv)
        begin
            r_valid_reg <= {r_valid_reg[2:0], rs_valid_reg[ROOT_STEPS]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg       <= r1_next;
            r2_reg       <= r2_next;
            r3_reg       <= r3_next;
            r3_c_two_reg <= r2_reg.c_two;
            r4_reg       <= r4_next;
        end
    end

    // z fraction, phi and output register
    logic [31:0] t_z;
    logic [31:0] t_phi;
    logic [1:0]  t_region;
    logic [14:0] t_ring;
    logic [15:0] t_iphi;
    logic        t_invalid;

    rpa_tail u_tail (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_valid      (r_valid_reg[3]),
        .in_item       (r4_reg),
        .out_valid     (m_axis_tvalid),
        .z_value       (t_z),
        .phi_value     (t_phi),
        .region        (t_region),
        .ring_number   (t_ring),
        .index_in_ring (t_iphi),
        .pixel_invalid (t_invalid)
    );

    assign adv          = !m_axis_tvalid || m_axis_tready;
    assign m_axis_tdata = {1'b0, t_iphi, t_ring, t_phi, t_z};
    assign m_axis_tuser = {t_invalid, t_region};

endmodule
